// ===== rtl/multi_term_line_filter_defines.svh =====
// Assertion macros used by the line filter top level.
`ifndef MULTI_TERM_LINE_FILTER_DEFINES_SVH
`define MULTI_TERM_LINE_FILTER_DEFINES_SVH

`ifndef SYNTH
// Clocked check, off while reset is asserted.
`define MTLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MTLF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTLF_ASSERT(lbl, prop, msg)
`define MTLF_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== rtl/mtlf_pkg.sv =====
// Shared types, constants and helper functions for the line filter.
package mtlf_pkg;

    localparam int NUM_TERM_REGS   = 4;
    localparam int MAX_TERMS_DEF   = 4;
    localparam int TERM_BYTES_DEF  = 8;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int ADDR_LSB    = 3;
    localparam int TERM_WORD_W = 64;
    localparam int LEN_FIELD_W = 4;
    localparam int LENGTHS_W   = 16;
    localparam int SKIP_W      = 16;
    localparam int RES_W       = 32;

    typedef logic [APB_ADDR_W-ADDR_LSB-1:0] reg_idx_t;

    localparam reg_idx_t REG_TERM_0       = 3'd0;
    localparam reg_idx_t REG_TERM_1       = 3'd1;
    localparam reg_idx_t REG_TERM_2       = 3'd2;
    localparam reg_idx_t REG_TERM_3       = 3'd3;
    localparam reg_idx_t REG_TERM_LENGTHS = 3'd4;
    localparam reg_idx_t REG_SKIP_COUNT   = 3'd5;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } text_item_t;

    typedef struct packed {
        logic [RES_W-1:0] line_start;
        logic [RES_W-1:0] line_length;
        logic             found;
        logic             done_res;
    } result_item_t;

    typedef struct packed {
        logic [SKIP_W-1:0] skip_count;
        logic              skip_load;
    } skip_ctl_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic [7:0] term_byte(input logic [TERM_WORD_W-1:0] word,
                                             input logic [2:0] idx);
        return word[8*idx +: 8];
    endfunction

endpackage

// ===== rtl/multi_term_line_filter.sv =====
// Top level of the case-insensitive multi-term line filter.
//
// Text enters on the text channel, one byte per request (text_valid, text_stall,
// text_data); last_byte marks the end of the database. A line ends at a newline
// (counted in the line) or at the last byte. A line matches when every enabled
// term occurs inside it, letters folded to lower case. After skip_count matches
// are passed over, each matching line is reported on the result channel as its
// start offset and length; the last byte always yields a request with done_res.
// Throughput: one byte per cycle. A row of window cells, one per term byte,
// shifts the folded text and compares every term in parallel each cycle. A result
// request appears in the cycle after the byte that ends its line. The result sits
// in one output register; while it is held by result_stall, text_stall is raised
// and no byte is taken, so no request is lost. Reset zeroes offsets, window, term
// flags and skip state, not result data. Configuration is written over APB
// (64-bit registers at 8-byte spacing) while the stream is idle, a user rule the
// block does not enforce; writing skip_count also loads the pending skip count.
module multi_term_line_filter #(
    parameter int MAX_TERMS   = mtlf_pkg::MAX_TERMS_DEF,
    parameter int TERM_BYTES  = mtlf_pkg::TERM_BYTES_DEF,
    parameter int OFFSET_BITS = mtlf_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtlf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mtlf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtlf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            text_valid,
    output logic                            text_stall,
    input  mtlf_pkg::text_item_t            text_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output mtlf_pkg::result_item_t          result_data
);
    import mtlf_pkg::*;

`include "multi_term_line_filter_defines.svh"

    localparam int NTERMS = (MAX_TERMS < NUM_TERM_REGS) ? MAX_TERMS : NUM_TERM_REGS;
    localparam logic [LEN_FIELD_W-1:0] TB_LEN  = LEN_FIELD_W'(TERM_BYTES);
    localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

    // configuration
    logic [NUM_TERM_REGS-1:0][TERM_WORD_W-1:0] term_word;
    logic [LENGTHS_W-1:0]                      term_lengths;
    skip_ctl_t                                 skip_ctl;

    mtlf_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .term_word    (term_word),
        .term_lengths (term_lengths),
        .skip_ctl     (skip_ctl)
    );

    // stream state
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] line_begin_reg, line_begin_next;
    logic [OFFSET_BITS-1:0] line_count_reg, line_count_next;
    logic [NTERMS-1:0]      term_seen_reg, term_seen_next;
    logic [SKIP_W-1:0]      skip_left_reg, skip_left_next;
    logic                   result_valid_reg, result_valid_next;
    result_item_t           result_data_reg, result_data_next;

    logic       accept;
    logic       last;
    logic [7:0] cur_byte;

    assign accept     = text_valid && !text_stall;
    assign text_stall = result_valid_reg && result_stall;
    assign last       = text_data.last_byte;
    assign cur_byte   = fold_lower(text_data.data_byte);

    // right-aligned term patterns: position 0 is the newest byte
    logic [LEN_FIELD_W-1:0]   len_sat [NTERMS];
    logic [NTERMS-1:0]        enabled;
    logic [NTERMS-1:0]        count_ok;
    logic [NTERMS-1:0][7:0]   pat [TERM_BYTES];
    logic [NTERMS-1:0]        care [TERM_BYTES];

    always_comb
    begin
        logic [LEN_FIELD_W-1:0] raw_len;
        logic [LEN_FIELD_W-1:0] pos_idx;
        for (int t = 0; t < NTERMS; t++)
        begin
            raw_len    = term_lengths[LEN_FIELD_W*t +: LEN_FIELD_W];
            len_sat[t] = (raw_len > TB_LEN) ? TB_LEN : raw_len;
            enabled[t] = (raw_len != '0);
            count_ok[t] = line_count_reg >= OFFSET_BITS'(len_sat[t] - LEN_FIELD_W'(1));
            for (int p = 0; p < TERM_BYTES; p++)
            begin
                care[p][t] = LEN_FIELD_W'(p) < len_sat[t];
                pos_idx    = len_sat[t] - LEN_FIELD_W'(p) - LEN_FIELD_W'(1);
                pat[p][t]  = care[p][t] ? fold_lower(term_byte(term_word[t], pos_idx[2:0]))
                                        : 8'h00;
            end
        end
    end

    // window: a chain of cells, cell 0 sees the incoming byte
    logic [7:0]        win_byte [TERM_BYTES];
    logic [NTERMS-1:0] cell_hit [TERM_BYTES];

    genvar k;
    generate
        for (k = 0; k < TERM_BYTES; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                mtlf_cell #(.NTERMS(NTERMS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (accept),
                    .clear    (accept && last),
                    .byte_in  (cur_byte),
                    .pat      (pat[k]),
                    .care     (care[k]),
                    .byte_out (win_byte[k]),
                    .hit      (cell_hit[k])
                );
            end
            else
            begin : g_body
                mtlf_cell #(.NTERMS(NTERMS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (accept),
                    .clear    (accept && last),
                    .byte_in  (win_byte[k-1]),
                    .pat      (pat[k]),
                    .care     (care[k]),
                    .byte_out (win_byte[k]),
                    .hit      (cell_hit[k])
                );
            end
        end
    endgenerate

    logic [NTERMS-1:0] hits;

    always_comb
    begin
        for (int t = 0; t < NTERMS; t++)
        begin
            hits[t] = enabled[t] && count_ok[t];
            for (int p = 0; p < TERM_BYTES; p++)
            begin
                hits[t] = hits[t] && cell_hit[p][t];
            end
        end
    end

    // line length including the terminating byte, saturating
    logic [OFFSET_BITS-1:0] line_len;
    logic [RES_W-1:0]       start_res;
    logic [RES_W-1:0]       len_res;

    assign line_len = (line_count_reg != OFS_MAX) ? line_count_reg + 1'b1 : line_count_reg;

    generate
        if (OFFSET_BITS >= RES_W)
        begin : g_res_trunc
            assign start_res = line_begin_reg[RES_W-1:0];
            assign len_res   = line_len[RES_W-1:0];
        end
        else
        begin : g_res_ext
            assign start_res = {{(RES_W-OFFSET_BITS){1'b0}}, line_begin_reg};
            assign len_res   = {{(RES_W-OFFSET_BITS){1'b0}}, line_len};
        end
    endgenerate

    always_comb
    begin
        logic [NTERMS-1:0] seen;
        logic              line_end;
        logic              report;
        seen     = term_seen_reg | hits;
        line_end = (text_data.data_byte == CHAR_NEWLINE) || last;
        report   = 1'b0;

        byte_offset_next  = byte_offset_reg;
        line_begin_next   = line_begin_reg;
        line_count_next   = line_count_reg;
        term_seen_next    = term_seen_reg;
        skip_left_next    = skip_left_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_data_next  = result_data_reg;

        if (skip_ctl.skip_load)
        begin
            skip_left_next = skip_ctl.skip_count;
        end

        if (accept)
        begin
            if (line_end)
            begin
                if ((seen & enabled) == enabled)
                begin
                    if (skip_left_reg != '0)
                    begin
                        skip_left_next = skip_left_reg - 1'b1;
                    end
                    else
                    begin
                        report = 1'b1;
                    end
                end
                line_begin_next = byte_offset_reg + 1'b1;
                line_count_next = '0;
                term_seen_next  = '0;
            end
            else
            begin
                if (line_count_reg != OFS_MAX)
                begin
                    line_count_next = line_count_reg + 1'b1;
                end
                term_seen_next = seen;
            end
            byte_offset_next = byte_offset_reg + 1'b1;

            if (last)
            begin
                byte_offset_next = '0;
                line_begin_next  = '0;
                line_count_next  = '0;
                term_seen_next   = '0;
                skip_left_next   = skip_ctl.skip_count;
            end

            result_valid_next = report || last;
            if (report || last)
            begin
                result_data_next.line_start  = report ? start_res : '0;
                result_data_next.line_length = report ? len_res : '0;
                result_data_next.found       = report;
                result_data_next.done_res    = last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            line_begin_reg   <= '0;
            line_count_reg   <= '0;
            term_seen_reg    <= '0;
            skip_left_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_offset_reg  <= byte_offset_next;
            line_begin_reg   <= line_begin_next;
            line_count_reg   <= line_count_next;
            term_seen_reg    <= term_seen_next;
            skip_left_reg    <= skip_left_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    `MTLF_ASSERT(a_done_clears,
        accept && last |=> byte_offset_reg == '0 && line_count_reg == '0 && term_seen_reg == '0,
        "stream state not cleared after last byte")
    `MTLF_ASSERT(a_result_kind,
        result_valid_reg |-> result_data_reg.found || result_data_reg.done_res,
        "result request with neither found nor done")
    `MTLF_ASSERT(a_nomatch_zero,
        result_valid_reg && !result_data_reg.found
            |-> result_data_reg.line_start == '0 && result_data_reg.line_length == '0,
        "done-only result carries a line")
    `MTLF_ASSERT_NR(a_reset_idle, !rst_n |-> !result_valid_reg && !text_stall,
        "output not idle in reset")

endmodule

// ===== rtl/mtlf_cell.sv =====
// One window cell: holds a recent text byte, matches its input against all terms.
module mtlf_cell #(
    parameter int NTERMS = mtlf_pkg::MAX_TERMS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift_en,
    input  logic                   clear,
    input  logic [7:0]             byte_in,
    input  logic [NTERMS-1:0][7:0] pat,
    input  logic [NTERMS-1:0]      care,
    output logic [7:0]             byte_out,
    output logic [NTERMS-1:0]      hit
);
    import mtlf_pkg::*;

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (clear)
        begin
            byte_reg <= '0;
        end
        else if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // a position outside a term's length always agrees
    always_comb
    begin
        for (int t = 0; t < NTERMS; t++)
        begin
            hit[t] = !care[t] || (pat[t] == byte_in);
        end
    end

endmodule

// ===== rtl/mtlf_regs.sv =====
// APB register file: search terms, term lengths and skip count.
module mtlf_regs (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 psel,
    input  logic                                                 penable,
    input  logic                                                 pwrite,
    input  logic [mtlf_pkg::APB_ADDR_W-1:0]                      paddr,
    input  logic [mtlf_pkg::APB_DATA_W-1:0]                      pwdata,
    output logic [mtlf_pkg::APB_DATA_W-1:0]                      prdata,
    output logic                                                 pready,
    output logic [mtlf_pkg::NUM_TERM_REGS-1:0][mtlf_pkg::TERM_WORD_W-1:0] term_word,
    output logic [mtlf_pkg::LENGTHS_W-1:0]                       term_lengths,
    output mtlf_pkg::skip_ctl_t                                  skip_ctl
);
    import mtlf_pkg::*;

    logic [NUM_TERM_REGS-1:0][TERM_WORD_W-1:0] term_word_reg;
    logic [LENGTHS_W-1:0]                      term_lengths_reg;
    logic [SKIP_W-1:0]                         skip_count_reg;
    logic                                      wr_en;
    reg_idx_t                                  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_W-1:ADDR_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_word_reg    <= '0;
            term_lengths_reg <= '0;
            skip_count_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (idx == REG_TERM_0 || idx == REG_TERM_1 || idx == REG_TERM_2
                || idx == REG_TERM_3)
            begin
                term_word_reg[idx[1:0]] <= pwdata;
            end
            else if (idx == REG_TERM_LENGTHS)
            begin
                term_lengths_reg <= pwdata[LENGTHS_W-1:0];
            end
            else if (idx == REG_SKIP_COUNT)
            begin
                skip_count_reg <= pwdata[SKIP_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (idx) inside
            REG_TERM_0, REG_TERM_1, REG_TERM_2, REG_TERM_3:
                prdata = term_word_reg[idx[1:0]];
            REG_TERM_LENGTHS:
                prdata = {{(APB_DATA_W-LENGTHS_W){1'b0}}, term_lengths_reg};
            REG_SKIP_COUNT:
                prdata = {{(APB_DATA_W-SKIP_W){1'b0}}, skip_count_reg};
            default:
                prdata = '0;
        endcase
    end

    assign term_word    = term_word_reg;
    assign term_lengths = term_lengths_reg;

    // skip_left follows skip_count on the write itself, else reloads from the stored count
    assign skip_ctl.skip_load  = wr_en && (idx == REG_SKIP_COUNT);
    assign skip_ctl.skip_count = skip_ctl.skip_load ? pwdata[SKIP_W-1:0] : skip_count_reg;

endmodule

// ===== dv/tb_multi_term_line_filter.sv =====
// Self-checking testbench for the multi-term line filter: line predictor, stall and hold-off traffic.
`timescale 1ns / 1ps

class line_report_board;
    logic [63:0] term_word [mtlf_pkg::NUM_TERM_REGS];
    logic [15:0] term_lens;
    logic [15:0] skip_reload;
    logic [15:0] skips_left;
    logic [7:0]  window [7];
    logic [3:0]  seen_terms;
    logic [31:0] byte_pos;
    logic [31:0] line_head;
    logic [31:0] line_bytes;
    mtlf_pkg::result_item_t expected_reports [$];
    int mismatches;

    function new();
        foreach (term_word[t])
            term_word[t] = '0;
        term_lens = '0;
        skip_reload = '0;
        skips_left = '0;
        mismatches = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (window[k])
            window[k] = '0;
        seen_terms = '0;
        byte_pos = '0;
        line_head = '0;
        line_bytes = '0;
    endfunction

    function logic [7:0] to_lower(logic [7:0] b);
        if (b >= mtlf_pkg::CHAR_UPPER_A && b <= mtlf_pkg::CHAR_UPPER_Z)
            return b + mtlf_pkg::CASE_OFFSET;
        return b;
    endfunction

    // Effective length of term t: 0 when disabled, capped at 8 bytes.
    function int live_len(int t);
        int n;
        n = int'(term_lens[4*t +: 4]);
        return (n > 8) ? 8 : n;
    endfunction

    function void write_reg(mtlf_pkg::reg_idx_t idx, logic [63:0] value);
        case (idx)
            mtlf_pkg::REG_TERM_0, mtlf_pkg::REG_TERM_1,
            mtlf_pkg::REG_TERM_2, mtlf_pkg::REG_TERM_3:
                term_word[idx - mtlf_pkg::REG_TERM_0] = value;
            mtlf_pkg::REG_TERM_LENGTHS:
                term_lens = value[15:0];
            mtlf_pkg::REG_SKIP_COUNT:
            begin
                skip_reload = value[15:0];
                skips_left = value[15:0];
            end
            default: ;
        endcase
    endfunction

    function void take_byte(mtlf_pkg::text_item_t it);
        logic [7:0] c;
        logic [7:0] hb;
        logic [3:0] enabled;
        logic [3:0] hits;
        logic [3:0] seen;
        logic [31:0] rep_len;
        bit hit;
        int n;
        mtlf_pkg::result_item_t r;
        c = to_lower(it.data_byte);
        enabled = '0;
        hits = '0;
        for (int t = 0; t < mtlf_pkg::NUM_TERM_REGS; t++)
        begin
            n = live_len(t);
            if (n == 0)
                continue;
            enabled[t] = 1'b1;
            // occurrence must lie wholly inside the current line
            if (line_bytes < 32'(n - 1))
                continue;
            hit = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (i == n - 1)
                    hb = c;
                else
                    hb = window[n - 2 - i];
                if (to_lower(term_word[t][8*i +: 8]) != hb)
                    hit = 1'b0;
            end
            hits[t] = hit;
        end
        seen = seen_terms | hits;
        for (int k = 6; k >= 1; k--)
            window[k] = window[k - 1];
        window[0] = c;

        r = '0;
        if (it.data_byte == mtlf_pkg::CHAR_NEWLINE || it.last_byte)
        begin
            rep_len = (line_bytes == '1) ? line_bytes : line_bytes + 1;
            if ((seen & enabled) == enabled)
            begin
                if (skips_left != 0)
                    skips_left--;
                else
                begin
                    r.found = 1'b1;
                    r.line_start = line_head;
                    r.line_length = rep_len;
                end
            end
            line_head = byte_pos + 1;
            line_bytes = '0;
            seen_terms = '0;
        end
        else
        begin
            if (line_bytes != '1)
                line_bytes++;
            seen_terms = seen;
        end
        byte_pos++;

        if (it.last_byte)
        begin
            clear_stream();
            skips_left = skip_reload;
            r.done_res = 1'b1;
        end
        if (r.found || r.done_res)
            expected_reports.push_back(r);
    endfunction

    function void check_result(mtlf_pkg::result_item_t got);
        mtlf_pkg::result_item_t want;
        if (expected_reports.size() == 0)
        begin
            $error("unexpected result: line_start %0d line_length %0d found %0b done_res %0b",
                   got.line_start, got.line_length, got.found, got.done_res);
            mismatches++;
            return;
        end
        want = expected_reports.pop_front();
        if (got.line_start !== want.line_start)
        begin
            $error("line_start: expected %0d, got %0d", want.line_start, got.line_start);
            mismatches++;
        end
        if (got.line_length !== want.line_length)
        begin
            $error("line_length: expected %0d, got %0d", want.line_length, got.line_length);
            mismatches++;
        end
        if (got.found !== want.found)
        begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            mismatches++;
        end
        if (got.done_res !== want.done_res)
        begin
            $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
            mismatches++;
        end
    endfunction
endclass

module tb_multi_term_line_filter;
    import mtlf_pkg::*;

    localparam int NUM_PHASES  = 10;
    localparam int PHASE_BYTES = 155;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_CYC  = 4;

    // register slots past the last real one; writes there must be ignored
    localparam reg_idx_t NO_REG_LO = REG_SKIP_COUNT + reg_idx_t'(1);
    localparam reg_idx_t NO_REG_HI = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  text_valid;
    logic                  text_stall;
    text_item_t            text_data;
    logic                  result_valid;
    logic                  result_stall;
    result_item_t          result_data;

    line_report_board board;
    int idle_odds;
    int bytes_sent;
    bit long_hold;

    multi_term_line_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_data    (text_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] flip_case(logic [7:0] b);
        if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1)
            return b ^ CASE_OFFSET;
        return b;
    endfunction

    // Mostly a small letter set so terms hit often, with some arbitrary bytes.
    function automatic logic [7:0] pool_byte();
        if ($urandom_range(0, 9) < 8)
            return flip_case(8'h61 + 8'($urandom_range(0, 2)));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {ADDR_LSB{1'b0}}};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        board.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(logic [7:0] b, bit last);
        text_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        text_valid <= 1'b1;
        text_data <= it;
        do
            @(posedge clk);
        while (text_stall !== 1'b0);
        board.take_byte(it);
        bytes_sent++;
        if ($urandom_range(0, 9) < idle_odds)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_text(string s, bit ends_db);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], ends_db && i == s.len() - 1);
    endtask

    // One database: a few lines of filler with the live terms dropped in.
    task automatic send_database(int n_lines);
        logic [7:0] line [$];
        logic [7:0] db [$];
        int n;
        int pos;
        for (int l = 0; l < n_lines; l++)
        begin
            line.delete();
            repeat ($urandom_range(0, 10)) line.push_back(pool_byte());
            for (int t = 0; t < NUM_TERM_REGS; t++)
            begin
                n = board.live_len(t);
                if (n != 0 && $urandom_range(0, 9) < 7)
                begin
                    pos = $urandom_range(0, line.size());
                    for (int i = n - 1; i >= 0; i--)
                        line.insert(pos, flip_case(board.term_word[t][8*i +: 8]));
                end
            end
            if (l != n_lines - 1 || $urandom_range(0, 1) == 1)
                line.push_back(CHAR_NEWLINE);
            if (line.size() == 0)
                line.push_back(pool_byte());
            foreach (line[k])
                db.push_back(line[k]);
        end
        foreach (db[k])
            send_item(db[k], k == db.size() - 1);
    endtask

    task automatic settle();
        while (board.expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if ($urandom_range(0, 9) < idle_odds)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
            board.check_result(result_data);
    end

    initial
    begin
        logic [63:0] w;
        logic [15:0] lens;
        logic [15:0] skips;
        int r;
        int mark;
        board = new();
        idle_odds = 3;
        bytes_sent = 0;
        long_hold = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        text_valid <= 1'b0;
        text_data <= '0;
        result_stall <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no term enabled: every line matches, final line carries found and done
        send_item(CHAR_NEWLINE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b1);
        text_valid <= 1'b0;
        settle();

        // "aZ" and "@": letter edges, one skipped match, a term split over two lines
        write_reg(REG_TERM_0, 64'h5A61);
        write_reg(REG_TERM_1, 64'h0);
        write_reg(REG_TERM_2, 64'h0);
        write_reg(REG_TERM_3, 64'h40);
        write_reg(REG_TERM_LENGTHS, 64'h1002);
        write_reg(REG_SKIP_COUNT, 64'h1);
        write_reg(NO_REG_LO, '1);
        send_text("Az@\n", 1'b0);
        send_text("a\nz@\n", 1'b0);
        send_text("[aZ@", 1'b1);
        text_valid <= 1'b0;
        settle();

        // length 15 saturates to 8; the match is skipped, so done comes alone
        write_reg(REG_TERM_0, '1);
        write_reg(REG_TERM_LENGTHS, 64'h000F);
        repeat (8) send_item(8'hFF, 1'b0);
        send_item(8'h2E, 1'b1);
        text_valid <= 1'b0;
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int t = 0; t < NUM_TERM_REGS; t++)
            begin
                for (int i = 0; i < 8; i++)
                    w[8*i +: 8] = pool_byte();
                if (ph == 3)
                    w = '0;
                if (ph == 4)
                    w = '1;
                write_reg(REG_TERM_0 + reg_idx_t'(t), w);
            end
            for (int t = 0; t < NUM_TERM_REGS; t++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    lens[4*t +: 4] = 4'd0;
                else if (r == 1)
                    lens[4*t +: 4] = 4'($urandom_range(9, 15));
                else
                    lens[4*t +: 4] = 4'($urandom_range(1, 3));
            end
            if (ph == 0)
                lens = '0;
            if (ph == 2)
                lens = '1;
            write_reg(REG_TERM_LENGTHS, {48'h0, lens});
            if ($urandom_range(0, 9) == 0)
                skips = 16'($urandom_range(0, 65535));
            else
                skips = 16'($urandom_range(0, 2));
            if (ph == 0)
                skips = '0;
            if (ph == 1)
                skips = '1;
            write_reg(REG_SKIP_COUNT, {48'h0, skips});
            if ($urandom_range(0, 1) == 1)
                write_reg(NO_REG_HI, {$urandom, $urandom});

            idle_odds = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 4);
            if (ph == 4)
                long_hold = 1'b1;
            mark = bytes_sent;
            while (bytes_sent - mark < PHASE_BYTES)
                send_database($urandom_range(1, 6));
            text_valid <= 1'b0;
            settle();
        end

        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
